// ===== sv/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the crontab time spec parser
// Character classes, parser phases, error codes, limit and name tables.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int unsigned MaskW = 60;

  typedef enum logic [3:0] {
    CL_DIGIT, CL_ALPHA, CL_SPACE, CL_DASH, CL_SLASH,
    CL_COMMA, CL_STAR, CL_AT, CL_OTHER, CL_END
  } cls_e;

  typedef enum logic [11:0] {
    PH_START = 12'b0000_0000_0001,
    PH_ITEM  = 12'b0000_0000_0010,
    PH_NUM1  = 12'b0000_0000_0100,
    PH_NAME1 = 12'b0000_0000_1000,
    PH_ITEM2 = 12'b0000_0001_0000,
    PH_NUM2  = 12'b0000_0010_0000,
    PH_NAME2 = 12'b0000_0100_0000,
    PH_STAR  = 12'b0000_1000_0000,
    PH_STEP0 = 12'b0001_0000_0000,
    PH_STEP  = 12'b0010_0000_0000,
    PH_GAP   = 12'b0100_0000_0000,
    PH_WORD  = 12'b1000_0000_0000
  } phase_e;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_TOKEN    = 3'd1;
  localparam logic [2:0] ERR_RANGE    = 3'd2;
  localparam logic [2:0] ERR_REVERSED = 3'd3;
  localparam logic [2:0] ERR_INTERVAL = 3'd4;
  localparam logic [2:0] ERR_EARLY    = 3'd5;

  localparam logic [2:0] FLD_MONTH   = 3'd3;
  localparam logic [2:0] FLD_WEEKDAY = 3'd4;

  // cell control, broadcast to every cell of the mask row
  typedef struct packed {
    logic load;
    logic shift;
    logic set;
    logic clr;
  } cell_ctrl_t;

  typedef logic [8:0][7:0] word_buf_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] val;
  } name_hit_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } iv_hit_t;

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    if (c >= 8'h30 && c <= 8'h39) r = CL_DIGIT;
    else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) r = CL_ALPHA;
    else if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) r = CL_SPACE;
    else if (c == 8'h2D) r = CL_DASH;
    else if (c == 8'h2F) r = CL_SLASH;
    else if (c == 8'h2C) r = CL_COMMA;
    else if (c == 8'h2A) r = CL_STAR;
    else if (c == 8'h40) r = CL_AT;
    else r = CL_OTHER;
    return r;
  endfunction

  function automatic logic [6:0] lo_lim(input logic [2:0] f);
    return (f == 3'd2 || f == FLD_MONTH) ? 7'd1 : 7'd0;
  endfunction

  function automatic logic [6:0] hi_lim(input logic [2:0] f);
    logic [6:0] r;
    unique case (f)
      3'd0:    r = 7'd59;
      3'd1:    r = 7'd23;
      3'd2:    r = 7'd31;
      3'd3:    r = 7'd12;
      default: r = 7'd6;
    endcase
    return r;
  endfunction

  function automatic name_hit_t name_lookup(input logic [2:0] f, input logic [23:0] s);
    name_hit_t r;
    r = '0;
    if (f == FLD_MONTH) begin
      r.hit = 1'b1;
      unique case (s)
        "JAN": r.val = 7'd1;
        "FEB": r.val = 7'd2;
        "MAR": r.val = 7'd3;
        "APR": r.val = 7'd4;
        "MAY": r.val = 7'd5;
        "JUN": r.val = 7'd6;
        "JUL": r.val = 7'd7;
        "AUG": r.val = 7'd8;
        "SEP": r.val = 7'd9;
        "OCT": r.val = 7'd10;
        "NOV": r.val = 7'd11;
        "DEC": r.val = 7'd12;
        default: r.hit = 1'b0;
      endcase
    end else if (f == FLD_WEEKDAY) begin
      r.hit = 1'b1;
      unique case (s)
        "SUN": r.val = 7'd0;
        "MON": r.val = 7'd1;
        "TUE": r.val = 7'd2;
        "WED": r.val = 7'd3;
        "THU": r.val = 7'd4;
        "FRI": r.val = 7'd5;
        "SAT": r.val = 7'd6;
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic iv_hit_t iv_match(input word_buf_t b, input logic [3:0] len);
    logic [71:0] s;
    iv_hit_t     r;
    s = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8]};
    r = '0;
    if (len == 4'd7 && s[71:16] == "@yearly") r = '{1'b1, 3'd0};
    else if (len == 4'd9 && s == "@annually") r = '{1'b1, 3'd1};
    else if (len == 4'd8 && s[71:8] == "@monthly") r = '{1'b1, 3'd2};
    else if (len == 4'd7 && s[71:16] == "@weekly") r = '{1'b1, 3'd3};
    else if (len == 4'd6 && s[71:24] == "@daily") r = '{1'b1, 3'd4};
    else if (len == 4'd7 && s[71:16] == "@hourly") r = '{1'b1, 3'd5};
    return r;
  endfunction

  // stored interval masks, already cut to each field's value count
  function automatic logic [MaskW-1:0] iv_mask(input logic [2:0] idx, input logic [2:0] f);
    logic [MaskW-1:0] r;
    r = 60'h1;
    unique case (f)
      3'd1:    if (idx == 3'd5) r = 60'hFF_FFFF;
      3'd2:    if (idx >= 3'd3) r = 60'h7FFF_FFFF;
      3'd3:    if (idx >= 3'd2) r = 60'hFFF;
      3'd4:    if (idx != 3'd3) r = 60'h7F;
      default: r = 60'h1;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/cts_cell.sv =====
// ----------------------------------------------------------------------------
// cts_cell: one value cell of the mask row
// Holds one mask bit and the walking token passed on from its left neighbor.
// ----------------------------------------------------------------------------
module cts_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cts_pkg::cell_ctrl_t ctrl_i,
  input  logic                load_here_i,
  input  logic                token_i,
  output logic                token_o,
  output logic                mask_o
);

  logic token_q, token_d;
  logic mask_q, mask_d;

  always_comb begin
    token_d = token_q;
    if (ctrl_i.load) token_d = load_here_i;
    else if (ctrl_i.shift) token_d = token_i;
    mask_d = mask_q;
    if (ctrl_i.clr) mask_d = 1'b0;
    else if (ctrl_i.set && token_q) mask_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
      mask_q  <= 1'b0;
    end else begin
      token_q <= token_d;
      mask_q  <= mask_d;
    end
  end

  assign token_o = token_q;
  assign mask_o  = mask_q;

endmodule

// ===== sv/cron_time_spec_parser_unit.sv =====
// ----------------------------------------------------------------------------
// cron_time_spec_parser_unit: crontab time field parser, one character a word
// Steps: a character passes accept, parse and finish, plus a load and a walk over
//   the mask bits that an item's value range spans (up to 60) when it closes the item,
//   plus an emit step per result word; a line end adds one more parse and finish pass.
// Throughput: one character at a time; the mask walk over the 60-cell row sets
//   the worst case, when the line end closes a 0-59 minute range.
// Reset: asynchronous, active low; the parser returns to start of line.
// ----------------------------------------------------------------------------
module cron_time_spec_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,   // line_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [2:0] field_index, [62:3] mask, [65:63] error
  output logic        m_axis_tlast_o    // last
);

  localparam int unsigned MaskW = cts_pkg::MaskW;

  // sequencer: process the character, walk the mask row, send results
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_PROC     = 8'b0000_0010,
    ST_LOAD     = 8'b0000_0100,
    ST_EXPAND   = 8'b0000_1000,
    ST_EMIT_FLD = 8'b0001_0000,
    ST_EMIT_IV  = 8'b0010_0000,
    ST_EMIT_ERR = 8'b0100_0000,
    ST_FIN      = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  cts_pkg::phase_e    phase_q, phase_d;
  logic [7:0]         ch_q, ch_d;
  logic               end_q, end_d;
  logic               pass_end_q, pass_end_d;
  logic [2:0]         fn_q, fn_d;
  logic [6:0]         rs_q, rs_d, re_q, re_d, step_q, step_d, acc_q, acc_d;
  logic               ov_q, ov_d;
  logic [3:0]         wlen_q, wlen_d;
  cts_pkg::word_buf_t buf_q, buf_d;
  logic               skip_q, skip_d;
  logic [2:0]         err_q, err_d;
  logic               comma_q, comma_d;
  logic [2:0]         iv_idx_q, iv_idx_d, ivcnt_q, ivcnt_d;
  logic [5:0]         pos_q, pos_d, cnt_q, cnt_d;

  // output register
  logic               ov_valid_q, ov_valid_d;
  logic [2:0]         o_fi_q, o_fi_d, o_err_q, o_err_d;
  logic [MaskW-1:0]   o_mask_q, o_mask_d;
  logic               o_last_q, o_last_d;

  cts_pkg::cell_ctrl_t cctl;
  logic [MaskW-1:0]    load_vec, tok, cmask;
  logic                line_rst;
  logic [2:0]          p_err;

  // derived values for the current field
  logic [2:0]          f;
  logic [6:0]          lo, hi;
  cts_pkg::cls_e       cls;
  logic [10:0]         acc_sum;
  logic [6:0]          acc_next;
  logic                ov_next, num_bad, step_bad, close_ok, in_acc, slot_free;
  cts_pkg::name_hit_t  nh;
  cts_pkg::iv_hit_t    ivh;
  logic [5:0]          s_idx, e_idx;

  assign f        = (fn_q > cts_pkg::FLD_WEEKDAY) ? cts_pkg::FLD_WEEKDAY : fn_q;
  assign lo       = cts_pkg::lo_lim(f);
  assign hi       = cts_pkg::hi_lim(f);
  assign cls      = pass_end_q ? cts_pkg::CL_END : cts_pkg::classify(ch_q);
  assign acc_sum  = 11'(acc_q) * 11'd10 + 11'(ch_q[3:0]);
  assign acc_next = (acc_sum > 11'd127) ? 7'd127 : acc_sum[6:0];
  assign ov_next  = ov_q | (acc_sum > 11'd127);
  assign num_bad  = ov_q || acc_q > hi || acc_q < lo;
  assign step_bad = ov_q || acc_q == 7'd0 || acc_q > hi + 7'd1;
  assign close_ok = cls == cts_pkg::CL_COMMA || cls == cts_pkg::CL_SPACE ||
                    cls == cts_pkg::CL_END;
  assign nh       = cts_pkg::name_lookup(f, {buf_q[0], buf_q[1], buf_q[2]});
  assign ivh      = cts_pkg::iv_match(buf_q, wlen_q);
  assign s_idx    = 6'(rs_q - lo);
  assign e_idx    = 6'(re_q - lo);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !ov_valid_q || m_axis_tready_i;

  always_comb begin
    state_d    = state_q;   phase_d   = phase_q;  ch_d     = ch_q;
    end_d      = end_q;     pass_end_d = pass_end_q; fn_d  = fn_q;
    rs_d       = rs_q;      re_d      = re_q;     step_d   = step_q;
    acc_d      = acc_q;     ov_d      = ov_q;     wlen_d   = wlen_q;
    buf_d      = buf_q;     skip_d    = skip_q;   err_d    = err_q;
    comma_d    = comma_q;   iv_idx_d  = iv_idx_q; ivcnt_d  = ivcnt_q;
    pos_d      = pos_q;     cnt_d     = cnt_q;
    ov_valid_d = ov_valid_q & ~m_axis_tready_i;
    o_fi_d     = o_fi_q;    o_err_d   = o_err_q;
    o_mask_d   = o_mask_q;  o_last_d  = o_last_q;
    cctl       = '0;
    line_rst   = 1'b0;
    p_err      = cts_pkg::ERR_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ch_d       = s_axis_tdata_i;
          end_d      = s_axis_tlast_i;
          pass_end_d = 1'b0;
          // after an error or the line's last result word the rest of the line is dropped
          if (skip_q) line_rst = s_axis_tlast_i;
          else state_d = ST_PROC;
        end
      end

      ST_PROC: begin
        unique case (phase_q)
          cts_pkg::PH_START, cts_pkg::PH_GAP, cts_pkg::PH_ITEM, cts_pkg::PH_ITEM2: begin
            if (phase_q == cts_pkg::PH_START && cls == cts_pkg::CL_AT) begin
              buf_d[0] = ch_q;
              wlen_d   = 4'd1;
              phase_d  = cts_pkg::PH_WORD;
            end else if (phase_q == cts_pkg::PH_GAP && cls == cts_pkg::CL_SPACE) begin
              phase_d = phase_q;
            end else if (phase_q != cts_pkg::PH_ITEM2 && cls == cts_pkg::CL_STAR) begin
              rs_d    = lo;
              re_d    = hi;
              phase_d = cts_pkg::PH_STAR;
            end else if (cls == cts_pkg::CL_DIGIT) begin
              acc_d   = 7'(ch_q[3:0]);
              ov_d    = 1'b0;
              phase_d = (phase_q == cts_pkg::PH_ITEM2) ? cts_pkg::PH_NUM2 : cts_pkg::PH_NUM1;
            end else if (cls == cts_pkg::CL_ALPHA && f >= cts_pkg::FLD_MONTH) begin
              buf_d[0] = ch_q;
              wlen_d   = 4'd1;
              phase_d  = (phase_q == cts_pkg::PH_ITEM2) ? cts_pkg::PH_NAME2 : cts_pkg::PH_NAME1;
            end else begin
              p_err = (cls == cts_pkg::CL_END) ? cts_pkg::ERR_EARLY : cts_pkg::ERR_TOKEN;
            end
          end
          cts_pkg::PH_NUM1, cts_pkg::PH_NAME1, cts_pkg::PH_NUM2, cts_pkg::PH_NAME2: begin
            if ((phase_q == cts_pkg::PH_NUM1 || phase_q == cts_pkg::PH_NUM2) &&
                cls == cts_pkg::CL_DIGIT) begin
              acc_d = acc_next;
              ov_d  = ov_next;
            end else if ((phase_q == cts_pkg::PH_NAME1 || phase_q == cts_pkg::PH_NAME2) &&
                         cls == cts_pkg::CL_ALPHA) begin
              if (wlen_q < 4'd9) buf_d[wlen_q] = ch_q;
              if (wlen_q < 4'd15) wlen_d = wlen_q + 4'd1;
            end else begin
              logic [6:0] tv;
              logic       bad;
              if (phase_q == cts_pkg::PH_NUM1 || phase_q == cts_pkg::PH_NUM2) begin
                acc_d = '0;
                ov_d  = 1'b0;
                tv    = acc_q;
                bad   = num_bad;
                if (bad) p_err = cts_pkg::ERR_RANGE;
              end else begin
                wlen_d = '0;
                tv     = nh.val;
                bad    = !(nh.hit && wlen_q == 4'd3);
                if (bad) p_err = cts_pkg::ERR_TOKEN;
              end
              if (!bad) begin
                if (phase_q == cts_pkg::PH_NUM1 || phase_q == cts_pkg::PH_NAME1) begin
                  rs_d = tv;
                  if (cls == cts_pkg::CL_DASH) phase_d = cts_pkg::PH_ITEM2;
                  else begin
                    re_d = tv;
                    if (cls == cts_pkg::CL_SLASH) phase_d = cts_pkg::PH_STEP0;
                    else if (!close_ok) p_err = cts_pkg::ERR_TOKEN;
                  end
                end else begin
                  re_d = tv;
                  if (tv < rs_q) p_err = cts_pkg::ERR_REVERSED;
                  else if (cls == cts_pkg::CL_SLASH) phase_d = cts_pkg::PH_STEP0;
                  else if (!close_ok) p_err = cts_pkg::ERR_TOKEN;
                end
              end
            end
          end
          cts_pkg::PH_STAR: begin
            if (cls == cts_pkg::CL_SLASH) phase_d = cts_pkg::PH_STEP0;
            else if (!close_ok) p_err = cts_pkg::ERR_TOKEN;
          end
          cts_pkg::PH_STEP0: begin
            if (cls == cts_pkg::CL_DIGIT) begin
              acc_d   = 7'(ch_q[3:0]);
              ov_d    = 1'b0;
              phase_d = cts_pkg::PH_STEP;
            end else begin
              p_err = (cls == cts_pkg::CL_END) ? cts_pkg::ERR_EARLY : cts_pkg::ERR_TOKEN;
            end
          end
          cts_pkg::PH_STEP: begin
            if (cls == cts_pkg::CL_DIGIT) begin
              acc_d = acc_next;
              ov_d  = ov_next;
            end else begin
              acc_d  = '0;
              ov_d   = 1'b0;
              step_d = acc_q;
              if (step_bad) p_err = cts_pkg::ERR_RANGE;
              else if (!close_ok) p_err = cts_pkg::ERR_TOKEN;
            end
          end
          cts_pkg::PH_WORD: begin
            if (cls == cts_pkg::CL_ALPHA) begin
              if (wlen_q < 4'd9) buf_d[wlen_q] = ch_q;
              if (wlen_q < 4'd15) wlen_d = wlen_q + 4'd1;
            end else if (!(cls == cts_pkg::CL_SPACE || cls == cts_pkg::CL_END) || !ivh.hit) begin
              p_err = cts_pkg::ERR_INTERVAL;
            end
          end
          default: p_err = cts_pkg::ERR_TOKEN;
        endcase

        // what the character leads to
        if (p_err != cts_pkg::ERR_OK) begin
          err_d   = p_err;
          state_d = ST_EMIT_ERR;
        end else if (phase_d == phase_q && close_ok && phase_q != cts_pkg::PH_START &&
                     (phase_q == cts_pkg::PH_NUM1 || phase_q == cts_pkg::PH_NAME1 ||
                      phase_q == cts_pkg::PH_NUM2 || phase_q == cts_pkg::PH_NAME2 ||
                      phase_q == cts_pkg::PH_STAR || phase_q == cts_pkg::PH_STEP)) begin
          comma_d = cls == cts_pkg::CL_COMMA;
          state_d = ST_LOAD;
        end else if (phase_q == cts_pkg::PH_WORD && cls != cts_pkg::CL_ALPHA) begin
          iv_idx_d = ivh.idx;
          ivcnt_d  = '0;
          state_d  = ST_EMIT_IV;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_LOAD: begin
        cctl.load = 1'b1;
        pos_d     = s_idx;
        cnt_d     = '0;
        state_d   = ST_EXPAND;
      end

      ST_EXPAND: begin
        // one cell a cycle; every step-th cell sets its bit
        cctl.set = cnt_q == '0;
        cnt_d    = (cnt_q == '0) ? 6'(step_q - 7'd1) : cnt_q - 6'd1;
        if (pos_q == e_idx) begin
          step_d = 7'd1;
          if (comma_q) begin
            phase_d = cts_pkg::PH_ITEM;
            state_d = ST_FIN;
          end else begin
            state_d = ST_EMIT_FLD;
          end
        end else begin
          cctl.shift = 1'b1;
          pos_d      = pos_q + 6'd1;
        end
      end

      ST_EMIT_FLD: begin
        if (slot_free) begin
          ov_valid_d = 1'b1;
          o_fi_d     = f;
          o_mask_d   = cmask;
          o_err_d    = cts_pkg::ERR_OK;
          o_last_d   = f == cts_pkg::FLD_WEEKDAY;
          cctl.clr   = 1'b1;
          if (f == cts_pkg::FLD_WEEKDAY) skip_d = 1'b1;
          else begin
            fn_d    = f + 3'd1;
            phase_d = cts_pkg::PH_GAP;
          end
          state_d = ST_FIN;
        end
      end

      ST_EMIT_IV: begin
        if (slot_free) begin
          ov_valid_d = 1'b1;
          o_fi_d     = ivcnt_q;
          o_mask_d   = cts_pkg::iv_mask(iv_idx_q, ivcnt_q);
          o_err_d    = cts_pkg::ERR_OK;
          o_last_d   = ivcnt_q == cts_pkg::FLD_WEEKDAY;
          ivcnt_d    = ivcnt_q + 3'd1;
          if (ivcnt_q == cts_pkg::FLD_WEEKDAY) begin
            skip_d  = 1'b1;
            state_d = ST_FIN;
          end
        end
      end

      ST_EMIT_ERR: begin
        if (slot_free) begin
          ov_valid_d = 1'b1;
          o_fi_d     = f;
          o_mask_d   = '0;
          o_err_d    = err_q;
          o_last_d   = 1'b1;
          skip_d     = 1'b1;
          state_d    = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!pass_end_q && end_q && !skip_q) begin
          // the line ends: run the parser once more on an end marker
          pass_end_d = 1'b1;
          state_d    = ST_PROC;
        end else if (pass_end_q && !skip_q) begin
          err_d   = cts_pkg::ERR_EARLY;
          state_d = ST_EMIT_ERR;
        end else begin
          line_rst = end_q;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (line_rst) begin
      fn_d     = '0;
      phase_d  = cts_pkg::PH_START;
      rs_d     = '0;
      re_d     = '0;
      step_d   = 7'd1;
      acc_d    = '0;
      ov_d     = 1'b0;
      wlen_d   = '0;
      skip_d   = 1'b0;
      cctl.clr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= cts_pkg::PH_START;
      pass_end_q <= 1'b0;
      end_q      <= 1'b0;
      fn_q       <= '0;
      rs_q       <= '0;
      re_q       <= '0;
      step_q     <= 7'd1;
      acc_q      <= '0;
      ov_q       <= 1'b0;
      wlen_q     <= '0;
      skip_q     <= 1'b0;
      comma_q    <= 1'b0;
      ivcnt_q    <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      ov_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      pass_end_q <= pass_end_d;
      end_q      <= end_d;
      fn_q       <= fn_d;
      rs_q       <= rs_d;
      re_q       <= re_d;
      step_q     <= step_d;
      acc_q      <= acc_d;
      ov_q       <= ov_d;
      wlen_q     <= wlen_d;
      skip_q     <= skip_d;
      comma_q    <= comma_d;
      ivcnt_q    <= ivcnt_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      ov_valid_q <= ov_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    buf_q    <= buf_d;
    err_q    <= err_d;
    iv_idx_q <= iv_idx_d;
    o_fi_q   <= o_fi_d;
    o_err_q  <= o_err_d;
    o_mask_q <= o_mask_d;
    o_last_q <= o_last_d;
  end

  // row of mask cells; the token walks from the range start to its end
  for (genvar i = 0; i < MaskW; i++) begin : g_cell
    assign load_vec[i] = s_idx == 6'(i);
    cts_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cctl),
      .load_here_i(load_vec[i]),
      .token_i    ((i == 0) ? 1'b0 : tok[(i == 0) ? 0 : i-1]),
      .token_o    (tok[i]),
      .mask_o     (cmask[i])
    );
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = ov_valid_q;
  assign m_axis_tdata_o  = {6'd0, o_err_q, o_mask_q, o_fi_q};
  assign m_axis_tlast_o  = o_last_q;

  a_err_zero_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_valid_q && o_err_q != cts_pkg::ERR_OK |-> o_mask_q == '0 && o_last_q)
    else $error("error word carries a mask");

  a_ok_last_weekday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_valid_q && o_last_q && o_err_q == cts_pkg::ERR_OK |-> o_fi_q == cts_pkg::FLD_WEEKDAY)
    else $error("last ok word is not the weekday field");

  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXPAND |-> $onehot(tok))
    else $error("mask walk token lost");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXPAND |-> pos_q <= e_idx && e_idx < 6'(MaskW))
    else $error("mask walk ran past range end");

endmodule

// ===== tb/cron_time_spec_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// cron_time_spec_parser_unit_tb: self-checking bench of the crontab parser
// Feeds schedule lines one character per word, predicts the field masks and
// error results in a behavioral parser and checks every output word in order.
// ----------------------------------------------------------------------------
module cron_time_spec_parser_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    logic [2:0]                fld;
    logic [cts_pkg::MaskW-1:0] mask;
    logic [2:0]                err;
    logic                      last;
  } field_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;

  always #5 clk_i = ~clk_i;

  cron_time_spec_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] ch
    .s_axis_tlast_i  (s_tlast),   // line_end
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [2:0] field, [62:3] mask, [65:63] error
    .m_axis_tlast_o  (m_tlast)    // last
  );

  // ---------------------------------------------------------------- predictor
  localparam logic [23:0] MonthNames [12] = '{"JAN", "FEB", "MAR", "APR", "MAY", "JUN",
                                              "JUL", "AUG", "SEP", "OCT", "NOV", "DEC"};
  localparam logic [23:0] DayNames [7] = '{"SUN", "MON", "TUE", "WED", "THU", "FRI", "SAT"};
  localparam logic [71:0] IvNames [6] = '{"@yearly", "@annually", "@monthly",
                                          "@weekly", "@daily", "@hourly"};
  localparam int IvLens [6] = '{7, 9, 8, 7, 6, 7};
  localparam logic [63:0] IvMasks [6][5] = '{
    '{64'h1, 64'h1, 64'h1, 64'h1, 64'hFF},
    '{64'h1, 64'h1, 64'h1, 64'h1, 64'hFF},
    '{64'h1, 64'h1, 64'h1, 64'hFFFF, 64'hFF},
    '{64'h1, 64'h1, 64'hFFFF_FFFF, 64'hFFFF, 64'h1},
    '{64'h1, 64'h1, 64'hFFFF_FFFF, 64'hFFFF, 64'hFF},
    '{64'h1, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF, 64'hFF}};
  localparam int FieldLo [5] = '{0, 0, 1, 1, 0};
  localparam int FieldHi [5] = '{59, 23, 31, 12, 6};

  // parser state mirror
  int              field_num, rng_lo, rng_hi, step_val, num_acc, word_len;
  logic            num_ovf, skip_line;
  cts_pkg::phase_e ph;
  logic [7:0]      word_chars [9];
  logic [63:0]     field_bits;

  field_result_t expected_q [$];
  int            fail_count = 0;

  function automatic cts_pkg::cls_e char_kind(input logic [7:0] c);
    if (c >= "0" && c <= "9") return cts_pkg::CL_DIGIT;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return cts_pkg::CL_ALPHA;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return cts_pkg::CL_SPACE;
    if (c == "-") return cts_pkg::CL_DASH;
    if (c == "/") return cts_pkg::CL_SLASH;
    if (c == ",") return cts_pkg::CL_COMMA;
    if (c == "*") return cts_pkg::CL_STAR;
    if (c == "@") return cts_pkg::CL_AT;
    return cts_pkg::CL_OTHER;
  endfunction

  function automatic int cur_field();
    return field_num > 4 ? 4 : field_num;
  endfunction

  task automatic clear_line();
    field_num = 0; ph = cts_pkg::PH_START; rng_lo = 0; rng_hi = 0; step_val = 1;
    num_acc = 0; num_ovf = 1'b0; word_len = 0; field_bits = '0; skip_line = 1'b0;
  endtask

  task automatic push_result(input int f, input logic [63:0] m, input logic [2:0] e,
                             input logic l);
    field_result_t r;
    r.fld = f[2:0]; r.mask = m[cts_pkg::MaskW-1:0]; r.err = e; r.last = l;
    expected_q.push_back(r);
  endtask

  task automatic add_digit(input logic [7:0] c);
    int v;
    v = num_acc * 10 + (c - "0");
    if (v > 127) begin
      v = 127; num_ovf = 1'b1;
    end
    num_acc = v;
  endtask

  task automatic add_letter(input logic [7:0] c);
    if (word_len < 9) word_chars[word_len] = c;
    if (word_len < 15) word_len++;
  endtask

  task automatic take_number(input int lo, input int hi, output int v, output logic [2:0] e);
    v = num_acc;
    e = (num_ovf || num_acc > hi || num_acc < lo) ? cts_pkg::ERR_RANGE : cts_pkg::ERR_OK;
    num_acc = 0; num_ovf = 1'b0;
  endtask

  task automatic take_name(output int v, output logic [2:0] e);
    logic [23:0] s;
    int          len;
    len = word_len; word_len = 0; e = cts_pkg::ERR_TOKEN; v = 0;
    if (len == 3) begin
      s = {word_chars[0], word_chars[1], word_chars[2]};
      if (cur_field() == cts_pkg::FLD_MONTH) begin
        for (int i = 0; i < 12; i++) if (s == MonthNames[i]) begin
          v = i + 1; e = cts_pkg::ERR_OK;
        end
      end else if (cur_field() == cts_pkg::FLD_WEEKDAY) begin
        for (int i = 0; i < 7; i++) if (s == DayNames[i]) begin
          v = i; e = cts_pkg::ERR_OK;
        end
      end
    end
  endtask

  task automatic close_item(input cts_pkg::cls_e k, output logic [2:0] e);
    int f;
    f = cur_field(); e = cts_pkg::ERR_OK;
    if (k != cts_pkg::CL_COMMA && k != cts_pkg::CL_SPACE && k != cts_pkg::CL_END) begin
      e = cts_pkg::ERR_TOKEN;
      return;
    end
    for (int v = rng_lo; v <= rng_hi; v += step_val)
      field_bits |= 64'd1 << ((v - FieldLo[f]) & 63);
    step_val = 1;
    if (k == cts_pkg::CL_COMMA) begin
      ph = cts_pkg::PH_ITEM;
      return;
    end
    push_result(f, field_bits, cts_pkg::ERR_OK, f == 4);
    field_bits = '0;
    if (f == 4) skip_line = 1'b1;
    else begin
      field_num = f + 1; ph = cts_pkg::PH_GAP;
    end
  endtask

  task automatic after_range(input cts_pkg::cls_e k, output logic [2:0] e);
    e = cts_pkg::ERR_OK;
    if (k == cts_pkg::CL_SLASH) ph = cts_pkg::PH_STEP0;
    else close_item(k, e);
  endtask

  task automatic item_start(input cts_pkg::cls_e k, input logic [7:0] c, input logic second,
                            output logic [2:0] e);
    int f;
    f = cur_field(); e = cts_pkg::ERR_OK;
    if (!second && k == cts_pkg::CL_STAR) begin
      rng_lo = FieldLo[f]; rng_hi = FieldHi[f]; ph = cts_pkg::PH_STAR;
    end else if (k == cts_pkg::CL_DIGIT) begin
      num_acc = 0; num_ovf = 1'b0; add_digit(c);
      ph = second ? cts_pkg::PH_NUM2 : cts_pkg::PH_NUM1;
    end else if (k == cts_pkg::CL_ALPHA && f >= 3) begin
      word_len = 0; add_letter(c);
      ph = second ? cts_pkg::PH_NAME2 : cts_pkg::PH_NAME1;
    end else e = (k == cts_pkg::CL_END) ? cts_pkg::ERR_EARLY : cts_pkg::ERR_TOKEN;
  endtask

  task automatic interval_close(input cts_pkg::cls_e k, output logic [2:0] e);
    logic [71:0] s;
    e = cts_pkg::ERR_INTERVAL; s = '0;
    if ((k != cts_pkg::CL_SPACE && k != cts_pkg::CL_END) || word_len < 2 || word_len > 9)
      return;
    for (int i = 0; i < word_len; i++) s = (s << 8) | word_chars[i];
    for (int i = 0; i < 6; i++) begin
      if (IvLens[i] == word_len && IvNames[i] == s) begin
        for (int f = 0; f < 5; f++)
          push_result(f, IvMasks[i][f] & ((64'd1 << (FieldHi[f] - FieldLo[f] + 1)) - 1),
                      cts_pkg::ERR_OK, f == 4);
        skip_line = 1'b1; e = cts_pkg::ERR_OK;
        return;
      end
    end
  endtask

  task automatic parse_char(input cts_pkg::cls_e k, input logic [7:0] c,
                            output logic [2:0] e);
    int f, v;
    f = cur_field(); e = cts_pkg::ERR_OK; v = 0;
    case (ph)
      cts_pkg::PH_START: begin
        if (k == cts_pkg::CL_AT) begin
          word_len = 0; add_letter(c); ph = cts_pkg::PH_WORD;
        end else item_start(k, c, 1'b0, e);
      end
      cts_pkg::PH_GAP:   if (k != cts_pkg::CL_SPACE) item_start(k, c, 1'b0, e);
      cts_pkg::PH_ITEM:  item_start(k, c, 1'b0, e);
      cts_pkg::PH_ITEM2: item_start(k, c, 1'b1, e);
      cts_pkg::PH_NUM1, cts_pkg::PH_NAME1: begin
        if (ph == cts_pkg::PH_NUM1 && k == cts_pkg::CL_DIGIT) add_digit(c);
        else if (ph == cts_pkg::PH_NAME1 && k == cts_pkg::CL_ALPHA) add_letter(c);
        else begin
          if (ph == cts_pkg::PH_NUM1) take_number(FieldLo[f], FieldHi[f], v, e);
          else take_name(v, e);
          if (e == cts_pkg::ERR_OK) begin
            rng_lo = v;
            if (k == cts_pkg::CL_DASH) ph = cts_pkg::PH_ITEM2;
            else begin
              rng_hi = rng_lo; after_range(k, e);
            end
          end
        end
      end
      cts_pkg::PH_NUM2, cts_pkg::PH_NAME2: begin
        if (ph == cts_pkg::PH_NUM2 && k == cts_pkg::CL_DIGIT) add_digit(c);
        else if (ph == cts_pkg::PH_NAME2 && k == cts_pkg::CL_ALPHA) add_letter(c);
        else begin
          if (ph == cts_pkg::PH_NUM2) take_number(FieldLo[f], FieldHi[f], v, e);
          else take_name(v, e);
          if (e == cts_pkg::ERR_OK) begin
            rng_hi = v;
            if (rng_hi < rng_lo) e = cts_pkg::ERR_REVERSED;
            else after_range(k, e);
          end
        end
      end
      cts_pkg::PH_STAR: after_range(k, e);
      cts_pkg::PH_STEP0: begin
        if (k == cts_pkg::CL_DIGIT) begin
          num_acc = 0; num_ovf = 1'b0; add_digit(c); ph = cts_pkg::PH_STEP;
        end else e = (k == cts_pkg::CL_END) ? cts_pkg::ERR_EARLY : cts_pkg::ERR_TOKEN;
      end
      cts_pkg::PH_STEP: begin
        if (k == cts_pkg::CL_DIGIT) add_digit(c);
        else begin
          take_number(1, FieldHi[f] + 1, v, e);
          if (e == cts_pkg::ERR_OK) begin
            step_val = v; close_item(k, e);
          end
        end
      end
      cts_pkg::PH_WORD: begin
        if (k == cts_pkg::CL_ALPHA) add_letter(c);
        else interval_close(k, e);
      end
      default: e = cts_pkg::ERR_TOKEN;
    endcase
  endtask

  // one accepted character: expected results go to expected_q
  task automatic predict_char(input logic [7:0] c, input logic eol);
    logic [2:0] e;
    e = cts_pkg::ERR_OK;
    if (!skip_line) begin
      parse_char(char_kind(c), c, e);
      if (e == cts_pkg::ERR_OK && eol && !skip_line) begin
        parse_char(cts_pkg::CL_END, 8'h00, e);
        if (e == cts_pkg::ERR_OK && !skip_line) e = cts_pkg::ERR_EARLY;
      end
      if (e != cts_pkg::ERR_OK) begin
        push_result(cur_field(), '0, e, 1'b1);
        skip_line = 1'b1;
      end
    end
    if (eol) clear_line();
  endtask

  // ---------------------------------------------------------------- driving
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int chars_sent = 0;

  task automatic send_char(input logic [7:0] c, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1; s_tdata <= c; s_tlast <= eol;
    // ready is stable between edges; sample it mid-cycle
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    @(posedge clk_i);
    predict_char(c, eol);
    chars_sent++;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req; hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word: field %0d mask %h err %0d last %0b", $realtime,
                 m_tdata[2:0], m_tdata[62:3], m_tdata[65:63], m_tlast);
        fail_count++;
      end else begin
        field_result_t x;
        x = expected_q.pop_front();
        if (m_tdata[2:0] !== x.fld || m_tdata[62:3] !== x.mask ||
            m_tdata[65:63] !== x.err || m_tlast !== x.last) begin
          $display("%0t mismatch: expected field %0d mask %h err %0d last %0b", $realtime,
                   x.fld, x.mask, x.err, x.last);
          $display("%0t           actual   field %0d mask %h err %0d last %0b", $realtime,
                   m_tdata[2:0], m_tdata[62:3], m_tdata[65:63], m_tlast);
          fail_count++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("cron_time_spec_parser_unit_tb NOT OK");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------- line maker
  function automatic string gen_item(input int f);
    string s;
    int    a, b, r;
    r = $urandom_range(99);
    a = $urandom_range(FieldLo[f], FieldHi[f]);
    b = $urandom_range(a, FieldHi[f]);
    if (r < 8) a = $urandom_range(0, 200);        // often out of range
    if (r < 20) s = "*";
    else if (r < 45) s = $sformatf("%0d", a);
    else if (r < 70 || f < 3) s = $sformatf("%0d-%0d", a, b);
    else if (f == 3) s = string'({MonthNames[a % 12], "-", MonthNames[11]});
    else s = string'({DayNames[a % 7], "-", DayNames[6]});
    if ($urandom_range(3) == 0) s = {s, $sformatf("/%0d", $urandom_range(1, FieldHi[f] + 2))};
    return s;
  endfunction

  function automatic string gen_line();
    string s;
    int    r;
    r = $urandom_range(99);
    if (r < 10) begin
      s = string'(IvNames[$urandom_range(5)]);
      if ($urandom_range(1)) s = {s, " cmd"};
      return s;
    end
    if (r < 15) begin
      s = "";
      for (int i = 0; i < $urandom_range(1, 6); i++) s = {s, " "};
      for (int i = 0; i < s.len(); i++) s.putc(i, $urandom_range(0, 255));
      return s;
    end
    s = "";
    for (int f = 0; f < 5; f++) begin
      if (f != 0) s = {s, " "};
      if (f != 0 && $urandom_range(3) == 0) s = {s, " "};
      s = {s, gen_item(f)};
      for (int i = 0; i < $urandom_range(0, 2) && $urandom_range(2) == 0; i++)
        s = {s, ",", gen_item(f)};
    end
    if ($urandom_range(1)) s = {s, " x"};
    r = $urandom_range(99);
    if (r < 10) s.putc($urandom_range(0, s.len() - 1), $urandom_range(0, 255));
    else if (r < 18) s = s.substr(0, $urandom_range(0, s.len() - 1));
    return s;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_fields();
    send_line("* * * * *");
    send_line("0-59/1 23 31 12 6");
    send_line("0,59 0-23/5 1-31/32 JAN-DEC SUN-SAT");
    send_line("*/60 */24 1 FEB,DEC MON,SAT/2");
  endtask

  task automatic test_intervals();
    for (int i = 0; i < 6; i++) send_line(string'(IvNames[i]));
    send_line("@daily echo");
    send_line("@Daily");
    send_line("@");
    send_line("@hourly!");
  endtask

  task automatic test_errors();
    send_line(" 1 2 3 4 5");      // leading white space
    send_line("1-* * * * *");     // star after dash
    send_line("1 2 MON * *");     // name in the day field
    send_line("* * * JAX *");     // unknown name
    send_line("999 * * * *");     // saturating number
    send_line("60 * * * *");      // above the field maximum
    send_line("5-3 * * * *");     // reversed range
    send_line("* * * *");         // line ends too early
    send_line("*/0 * * * *");     // zero step
    send_line("1/");
  endtask

  task automatic test_random(input int send_pct, input int rx_pct, input int count);
    int start;
    send_idle_pct = send_pct; stall_pct = rx_pct;
    start = chars_sent;
    while (chars_sent - start < count) send_line(gen_line());
    wait_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; stall_pct = 0;
    hold_req <= hold_req + 1;
    send_line("0-59 0-23 1-31 1-12 0-6");
    wait_results();
  endtask

  initial begin
    clear_line();
    for (int i = 0; i < 9; i++) word_chars[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fields();
    test_intervals();
    test_errors();
    wait_results();
    test_random(0, 0, 10);
    test_random(64, 0, 10);
    test_random(0, 64, 10);
    test_random(15, 15, 10);
    test_backpressure();
    wait_results();
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) $display("cron_time_spec_parser_unit_tb OK");
    else $display("cron_time_spec_parser_unit_tb NOT OK");
    $finish;
  end

endmodule
